// File: design/torque_angular_impulse_defines.svh
// assertion macros used by the back end
`ifndef TORQUE_ANGULAR_IMPULSE_DEFINES_SVH
`define TORQUE_ANGULAR_IMPULSE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TAI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define TAI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/tai_pkg.sv
// shared types, constants and fixed-point helpers of the angular impulse block
package tai_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int ACC_W     = 36;
    localparam int PROD_W    = 2 * DW;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_WX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_YZ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_45 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_67 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_8  = 3'd6;

    typedef logic signed [DW-1:0] tai_word_t;

    // one input request
    typedef struct packed {
        tai_word_t px;
        tai_word_t py;
        tai_word_t pz;
        tai_word_t fx;
        tai_word_t fy;
        tai_word_t fz;
    } tai_item_t;

    // configuration seen by the back end; quat is w, x, y, z at 0..3
    typedef struct packed {
        tai_word_t [3:0] quat;
        tai_word_t [8:0] inertia;
        logic            stale;
    } tai_cfg_t;

    // back end requests toward the front end
    typedef struct packed {
        logic pop;
        logic stale_clr;
    } tai_bctl_t;

    // quaternion product operands: xx yy zz xy xz yz wx wy wz
    localparam logic [1:0] QA_SEL [0:8] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
    localparam logic [1:0] QB_SEL [0:8] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};

    // cross product operands: py*fz pz*fy pz*fx px*fz px*fy py*fx
    localparam logic [1:0] TP_SEL [0:5] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] TF_SEL [0:5] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

    // overflow of a wide value against the signed word range
    function automatic logic ovf_word(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (PROD_W)'(signed'({1'b0, {(DW-1){1'b1}}}));
        lo = -hi - 1;
        return (x > hi) || (x < lo);
    endfunction

    // clip a wide value to the signed word range
    function automatic tai_word_t sat_word(input logic signed [PROD_W-1:0] x);
        tai_word_t r;
        if (!ovf_word(x))
            r = x[DW-1:0];
        else if (x[PROD_W-1])
            r = {1'b1, {(DW-1){1'b0}}};
        else
            r = {1'b0, {(DW-1){1'b1}}};
        return r;
    endfunction

    // sign extension of an accumulator value
    function automatic logic signed [PROD_W-1:0] acc_ext(input logic signed [ACC_W-1:0] x);
        return {{(PROD_W-ACC_W){x[ACC_W-1]}}, x};
    endfunction

    // sign extension of a word into accumulator width
    function automatic logic signed [ACC_W-1:0] word_ext(input tai_word_t x);
        return {{(ACC_W-DW){x[DW-1]}}, x};
    endfunction

    // flat index of a 3x3 matrix entry
    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

// File: design/tai_front.sv
// front end: configuration registers and the two-entry request queue
module tai_front
    import tai_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tai_item_t            item_in,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROD_W-1:0]    cfg_data,
    input  tai_bctl_t            bctl,
    output logic                 item_avail,
    output tai_item_t            item_out,
    output tai_cfg_t             cfg
);

    tai_item_t       queue_reg [0:1];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      count_reg;
    tai_word_t [3:0] quat_reg;
    tai_word_t [8:0] inertia_reg;
    logic            stale_reg;
    logic            do_push, do_pop;

    assign cfg_ready  = 1'b1;
    assign full       = count_reg[1];
    assign item_avail = (count_reg != 2'd0);
    assign item_out   = queue_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = bctl.pop && item_avail;

    assign cfg.quat    = quat_reg;
    assign cfg.inertia = inertia_reg;
    assign cfg.stale   = stale_reg;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            queue_reg[wptr_reg] <= item_in;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // configuration registers; a valid write to a defined index marks the world tensor stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg    <= '0;
            inertia_reg <= '0;
            stale_reg   <= 1'b1;
        end
        else
        begin
            if (bctl.stale_clr)
                stale_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ORIENT_WX:
                    begin
                        quat_reg[0] <= cfg_data[DW-1:0];
                        quat_reg[1] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_ORIENT_YZ:
                    begin
                        quat_reg[2] <= cfg_data[DW-1:0];
                        quat_reg[3] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_INERTIA_01:
                    begin
                        inertia_reg[0] <= cfg_data[DW-1:0];
                        inertia_reg[1] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_INERTIA_23:
                    begin
                        inertia_reg[2] <= cfg_data[DW-1:0];
                        inertia_reg[3] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_INERTIA_45:
                    begin
                        inertia_reg[4] <= cfg_data[DW-1:0];
                        inertia_reg[5] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_INERTIA_67:
                    begin
                        inertia_reg[6] <= cfg_data[DW-1:0];
                        inertia_reg[7] <= cfg_data[PROD_W-1:DW];
                    end
                    REG_INERTIA_8:
                        inertia_reg[8] <= cfg_data[DW-1:0];
                    default: ;
                endcase
                if (cfg_index <= REG_INERTIA_8)
                    stale_reg <= 1'b1;
            end
        end
    end

endmodule

// File: design/tai_back.sv
// back end: sequencer around one shared multiplier, tensor and spin update
module tai_back
    import tai_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_avail,
    input  tai_item_t item_in,
    input  tai_cfg_t  cfg,
    output tai_bctl_t bctl,
    input  logic      pop,
    output logic      empty,
    output tai_word_t spin_x,
    output tai_word_t spin_y,
    output tai_word_t spin_z,
    output logic      saturated
);

`include "torque_angular_impulse_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_Q, S_RWAIT, S_RCALC, S_A, S_W, S_T, S_D, S_DRAIN, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        DST_QP, DST_A, DST_W, DST_T, DST_V
    } dst_t;

    typedef struct packed {
        logic       valid;
        dst_t       dst;
        logic [3:0] idx;
        logic       first;
        logic       last;
        logic       neg;
    } tag_t;

    state_t                  state_reg;
    logic [3:0]              cnt_reg;
    logic [1:0]              ci_reg, cj_reg, ck_reg;
    tai_word_t               p_reg [0:2];
    tai_word_t               f_reg [0:2];
    tai_word_t               qp_reg [0:8];
    tai_word_t               r_reg [0:8];
    tai_word_t               a_reg [0:8];
    tai_word_t               w_reg [0:8];
    tai_word_t               t_reg [0:2];
    tai_word_t               v_reg [0:2];
    logic signed [PROD_W-1:0] prod_reg;
    tag_t                    tag_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    tai_word_t               out_x_reg, out_y_reg, out_z_reg;
    logic                    out_sat_reg;

    tai_word_t               op_a, op_b;
    tag_t                    tag_next;
    logic                    take;
    logic                    load_out;
    logic                    k_end, j_end, i_end;

    // product rounding and accumulation
    logic signed [PROD_W-1:0] rnd_shift;
    tai_word_t               rp;
    logic                    pclip;
    logic signed [ACC_W-1:0] sum;
    tai_word_t               s_sat;
    logic                    s_clip;
    logic signed [ACC_W-1:0] vsum;
    tai_word_t               v_sat;
    logic                    v_clip;
    logic                    item_clip;

    // one entry of the rotation matrix from two quaternion products
    function automatic tai_word_t r_entry(input logic use_one, input tai_word_t a,
                                          input tai_word_t b, input logic neg_b);
        logic signed [ACC_W-1:0] one;
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] val;
        one = ACC_W'(1) <<< FRAC_BITS;
        if (use_one)
        begin
            s   = word_ext(a) + word_ext(b);
            val = one - (s <<< 1);
        end
        else
        begin
            s   = neg_b ? (word_ext(a) - word_ext(b)) : (word_ext(a) + word_ext(b));
            val = s <<< 1;
        end
        return sat_word(acc_ext(val));
    endfunction

    assign take   = (state_reg == S_IDLE) && item_avail;
    assign bctl.pop       = take;
    assign bctl.stale_clr = take && cfg.stale;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || pop);
    assign k_end  = (ck_reg == 2'd2);
    assign j_end  = (cj_reg == 2'd2);
    assign i_end  = (ci_reg == 2'd2);

    assign empty     = !out_valid_reg;
    assign spin_x    = out_x_reg;
    assign spin_y    = out_y_reg;
    assign spin_z    = out_z_reg;
    assign saturated = out_sat_reg;

    // operand and tag selection for the multiplier
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        tag_next = '0;
        unique case (state_reg)
            S_Q:
            begin
                op_a     = cfg.quat[QA_SEL[cnt_reg]];
                op_b     = cfg.quat[QB_SEL[cnt_reg]];
                tag_next = '{1'b1, DST_QP, cnt_reg, 1'b1, 1'b1, 1'b0};
            end
            S_A:
            begin
                op_a     = r_reg[idx3(ci_reg, ck_reg)];
                op_b     = cfg.inertia[idx3(ck_reg, cj_reg)];
                tag_next = '{1'b1, DST_A, idx3(ci_reg, cj_reg), ck_reg == 2'd0, k_end, 1'b0};
            end
            S_W:
            begin
                op_a     = a_reg[idx3(ci_reg, ck_reg)];
                op_b     = r_reg[idx3(cj_reg, ck_reg)];
                tag_next = '{1'b1, DST_W, idx3(ci_reg, cj_reg), ck_reg == 2'd0, k_end, 1'b0};
            end
            S_T:
            begin
                op_a     = p_reg[TP_SEL[cnt_reg[2:0]]];
                op_b     = f_reg[TF_SEL[cnt_reg[2:0]]];
                tag_next = '{1'b1, DST_T, {2'b00, cnt_reg[2:1]}, !cnt_reg[0], cnt_reg[0],
                             cnt_reg[0]};
            end
            S_D:
            begin
                op_a     = w_reg[idx3(ci_reg, ck_reg)];
                op_b     = t_reg[ck_reg];
                tag_next = '{1'b1, DST_V, {2'b00, ci_reg}, ck_reg == 2'd0, k_end, 1'b0};
            end
            default: ;
        endcase
    end

    // second stage: round, clip, accumulate
    always_comb
    begin
        rnd_shift = (prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        pclip     = ovf_word(rnd_shift);
        rp        = sat_word(rnd_shift);
        sum       = (tag_reg.first ? '0 : acc_reg)
                  + (tag_reg.neg ? -word_ext(rp) : word_ext(rp));
        s_clip    = ovf_word(acc_ext(sum));
        s_sat     = sat_word(acc_ext(sum));
        vsum      = word_ext(v_reg[tag_reg.idx[1:0]]) + word_ext(s_sat);
        v_clip    = ovf_word(acc_ext(vsum));
        v_sat     = sat_word(acc_ext(vsum));
        item_clip = 1'b0;
        if (tag_reg.valid && (tag_reg.dst == DST_T || tag_reg.dst == DST_V))
            item_clip = pclip || (tag_reg.last && s_clip)
                     || (tag_reg.last && tag_reg.dst == DST_V && v_clip);
    end

    // multiplier stage and working storage
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (take)
        begin
            p_reg[0] <= item_in.px;
            p_reg[1] <= item_in.py;
            p_reg[2] <= item_in.pz;
            f_reg[0] <= item_in.fx;
            f_reg[1] <= item_in.fy;
            f_reg[2] <= item_in.fz;
        end
        if (tag_reg.valid)
        begin
            acc_reg <= sum;
            if (tag_reg.last)
            begin
                case (tag_reg.dst)
                    DST_QP:  qp_reg[tag_reg.idx] <= rp;
                    DST_A:   a_reg[tag_reg.idx] <= s_sat;
                    DST_W:   w_reg[tag_reg.idx] <= s_sat;
                    DST_T:   t_reg[tag_reg.idx[1:0]] <= s_sat;
                    default: ;
                endcase
            end
        end
        // rotation matrix from the quaternion products
        if (state_reg == S_RCALC)
        begin
            r_reg[0] <= r_entry(1'b1, qp_reg[1], qp_reg[2], 1'b0);
            r_reg[1] <= r_entry(1'b0, qp_reg[3], qp_reg[8], 1'b1);
            r_reg[2] <= r_entry(1'b0, qp_reg[4], qp_reg[7], 1'b0);
            r_reg[3] <= r_entry(1'b0, qp_reg[3], qp_reg[8], 1'b0);
            r_reg[4] <= r_entry(1'b1, qp_reg[0], qp_reg[2], 1'b0);
            r_reg[5] <= r_entry(1'b0, qp_reg[5], qp_reg[6], 1'b1);
            r_reg[6] <= r_entry(1'b0, qp_reg[4], qp_reg[7], 1'b1);
            r_reg[7] <= r_entry(1'b0, qp_reg[5], qp_reg[6], 1'b0);
            r_reg[8] <= r_entry(1'b1, qp_reg[0], qp_reg[1], 1'b0);
        end
    end

    // sequencer, spin state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            tag_reg       <= '0;
            clip_reg      <= 1'b0;
            v_reg         <= '{default: '0};
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            tag_reg <= tag_next;
            if (item_clip)
                clip_reg <= 1'b1;
            if (tag_reg.valid && tag_reg.last && tag_reg.dst == DST_V)
                v_reg[tag_reg.idx[1:0]] <= v_sat;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    ci_reg  <= '0;
                    cj_reg  <= '0;
                    ck_reg  <= '0;
                    if (take)
                    begin
                        clip_reg  <= 1'b0;
                        state_reg <= cfg.stale ? S_Q : S_T;
                    end
                end
                S_Q:
                begin
                    if (cnt_reg == 4'd8)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RWAIT;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                S_RWAIT:
                    state_reg <= S_RCALC;
                S_RCALC:
                    state_reg <= S_A;
                S_A, S_W:
                begin
                    ck_reg <= k_end ? 2'd0 : ck_reg + 2'd1;
                    if (k_end)
                    begin
                        cj_reg <= j_end ? 2'd0 : cj_reg + 2'd1;
                        if (j_end)
                            ci_reg <= i_end ? 2'd0 : ci_reg + 2'd1;
                    end
                    if (k_end && j_end && i_end)
                        state_reg <= (state_reg == S_A) ? S_W : S_T;
                end
                S_T:
                begin
                    if (cnt_reg == 4'd5)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_D;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                S_D:
                begin
                    ck_reg <= k_end ? 2'd0 : ck_reg + 2'd1;
                    if (k_end)
                        ci_reg <= i_end ? 2'd0 : ci_reg + 2'd1;
                    if (k_end && i_end)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (load_out)
                    begin
                        out_x_reg     <= v_reg[0];
                        out_y_reg     <= v_reg[1];
                        out_z_reg     <= v_reg[2];
                        out_sat_reg   <= clip_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks on sequencing and the result register
    `TAI_ASSERT_NOW(a_pop_idle, bctl.pop, state_reg == S_IDLE)
    `TAI_ASSERT_NEXT(a_result_held, out_valid_reg && !pop, out_valid_reg)
    `TAI_ASSERT_NOW(a_drained_at_done, state_reg == S_DONE, !tag_reg.valid)

endmodule

// File: design/torque_angular_impulse.sv
// top level of the angular impulse accumulator
// Each request (contact point, force) adds world_tensor * (point x force) to the stored
// angular velocity and yields one result with the new spin and a clip flag. All products
// go through one shared 32x32 multiplier, one per cycle: a request runs 6 cross-product
// and 9 tensor products between its accept, a drain step and the result load. The first
// request after reset or after a write to a defined configuration register first rebuilds
// the world tensor (9 quaternion products, rotation matrix, 27 + 27 matrix products).
// Up to two requests queue at the input while a finished result waits to be popped.
module torque_angular_impulse
    import tai_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tai_word_t            point_x,
    input  tai_word_t            point_y,
    input  tai_word_t            point_z,
    input  tai_word_t            force_x,
    input  tai_word_t            force_y,
    input  tai_word_t            force_z,
    output logic                 empty,
    input  logic                 pop,
    output tai_word_t            spin_x,
    output tai_word_t            spin_y,
    output tai_word_t            spin_z,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROD_W-1:0]    cfg_data
);

    tai_item_t item_in, item_head;
    tai_cfg_t  cfg;
    tai_bctl_t bctl;
    logic      item_avail;

    // request fields into one record
    assign item_in = '{point_x, point_y, point_z, force_x, force_y, force_z};

    // request queue and configuration
    tai_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item_in    (item_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bctl       (bctl),
        .item_avail (item_avail),
        .item_out   (item_head),
        .cfg        (cfg)
    );

    // arithmetic sequencer
    tai_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_avail (item_avail),
        .item_in    (item_head),
        .cfg        (cfg),
        .bctl       (bctl),
        .pop        (pop),
        .empty      (empty),
        .spin_x     (spin_x),
        .spin_y     (spin_y),
        .spin_z     (spin_z),
        .saturated  (saturated)
    );

endmodule
